// ===== rtl/kdl_pkg.sv =====
// Shared types, codes and constants for the key debounce latch.
// No dependencies; every other file imports this package.
package kdl_pkg;

  localparam int unsigned KeyW   = 8;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned HoldW  = 3;
  localparam int unsigned IdleW  = 7;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [HoldW-1:0] HoldNormal = 3'd3;
  localparam logic [HoldW-1:0] HoldCont   = 3'd6;
  localparam logic [IdleW-1:0] IdleLimit  = 7'd120;

  typedef enum logic [ModeW-1:0] {
    MODE_SAMPLE   = 2'd0,
    MODE_READ_KEY = 2'd1,
    MODE_READ_FN  = 2'd2
  } mode_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_CONT_MODE   = 3'd0,
    REG_BEEP_ENABLE = 3'd1,
    REG_NO_KEY      = 3'd2,
    REG_ENTER       = 3'd3,
    REG_CANCEL      = 3'd4,
    REG_FN          = 3'd5,
    REG_FUN2        = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic            continuous_mode;
    logic            beep_enable;
    logic [KeyW-1:0] no_key_code;
    logic [KeyW-1:0] enter_code;
    logic [KeyW-1:0] cancel_code;
    logic [KeyW-1:0] fn_code;
    logic [KeyW-1:0] fun2_code;
  } cfg_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [KeyW-1:0]  key_sample;
    logic             powered_off;
  } item_t;

  typedef struct packed {
    logic [KeyW-1:0] key_out;
    logic            beep;
  } result_t;

  function automatic logic is_fn_key(input cfg_t cfg, input logic [KeyW-1:0] k);
    return (k == cfg.fn_code) || (k == cfg.fun2_code);
  endfunction

  function automatic logic is_release_only(input cfg_t cfg, input logic [KeyW-1:0] k);
    return (k == cfg.enter_code) || (k == cfg.cancel_code) || is_fn_key(cfg, k);
  endfunction

endpackage

// ===== rtl/kdl_if.sv =====
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on kdl_pkg for field widths.
interface kdl_in_if;
  import kdl_pkg::*;
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [KeyW-1:0]  key_sample;
  logic             powered_off;
  modport source (output valid, output mode, output key_sample, output powered_off,
                  input ready);
  modport sink   (input valid, input mode, input key_sample, input powered_off,
                  output ready);
endinterface

interface kdl_out_if;
  import kdl_pkg::*;
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] key_out;
  logic            beep;
  modport source (output valid, output key_out, output beep, input ready);
  modport sink   (input valid, input key_out, input beep, output ready);
endinterface

interface kdl_cfg_if;
  import kdl_pkg::*;
  logic                valid;
  logic                ready;
  logic [RegIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/kdl_cfg_regs.sv =====
// Configuration register file of the key debounce latch.
// Depends on kdl_pkg and kdl_cfg_if.
module kdl_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  kdl_cfg_if.sink       cfg_i,
  output kdl_pkg::cfg_t cfg_o
);
  import kdl_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_CONT_MODE:   cfg_d.continuous_mode = cfg_i.data[0];
        REG_BEEP_ENABLE: cfg_d.beep_enable     = cfg_i.data[0];
        REG_NO_KEY:      cfg_d.no_key_code     = cfg_i.data;
        REG_ENTER:       cfg_d.enter_code      = cfg_i.data;
        REG_CANCEL:      cfg_d.cancel_code     = cfg_i.data;
        REG_FN:          cfg_d.fn_code         = cfg_i.data;
        REG_FUN2:        cfg_d.fun2_code       = cfg_i.data;
        default:         cfg_d = cfg_q; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.continuous_mode <= 1'b0;
      cfg_q.beep_enable     <= 1'b0;
      cfg_q.no_key_code     <= 8'd0;
      cfg_q.enter_code      <= 8'd1;
      cfg_q.cancel_code     <= 8'd2;
      cfg_q.fn_code         <= 8'd3;
      cfg_q.fun2_code       <= 8'd4;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/kdl_core.sv =====
// Debounce, latch and consume logic with its state registers.
// Depends on kdl_pkg.
module kdl_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kdl_pkg::cfg_t    cfg_i,
  input  kdl_pkg::item_t   item_i,
  input  logic             advance_i,
  output kdl_pkg::result_t result_o
);
  import kdl_pkg::*;

  logic [KeyW-1:0]  prev_q, prev_d;
  logic [HoldW-1:0] hold_q, hold_d;
  logic [IdleW-1:0] idle_q, idle_d;
  logic [KeyW-1:0]  latched_q, latched_d;

  logic [HoldW-1:0] thr;
  logic [HoldW-1:0] hold_inc;
  logic [IdleW-1:0] idle_inc;

  always_comb begin
    prev_d    = prev_q;
    hold_d    = hold_q;
    idle_d    = idle_q;
    latched_d = latched_q;
    result_o.key_out = latched_q;
    result_o.beep    = 1'b0;
    thr      = cfg_i.continuous_mode ? HoldCont : HoldNormal;
    hold_inc = (hold_q < thr) ? hold_q + 3'd1 : hold_q;
    idle_inc = idle_q + 7'd1;

    case (mode_e'(item_i.mode))
      MODE_SAMPLE: begin
        if (!item_i.powered_off) begin
          if (item_i.key_sample != cfg_i.no_key_code) begin
            idle_d = '0;
            if (item_i.key_sample == prev_q) begin
              hold_d = hold_inc;
              if (hold_inc >= thr) begin
                if (cfg_i.continuous_mode && !is_release_only(cfg_i, item_i.key_sample)) begin
                  latched_d = item_i.key_sample;
                  hold_d    = '0;
                end
                result_o.beep = cfg_i.beep_enable;
              end
            end else begin
              latched_d = cfg_i.no_key_code;
              hold_d    = '0;
            end
          end else begin
            // release: latch a qualified key unless it already repeated
            if (hold_q >= thr && (!cfg_i.continuous_mode || is_release_only(cfg_i, prev_q))) begin
              latched_d = prev_q;
            end
            hold_d = '0;
            if (idle_inc >= IdleLimit) begin
              latched_d = cfg_i.no_key_code;
              idle_d    = '0;
            end else begin
              idle_d = idle_inc;
            end
          end
          prev_d = item_i.key_sample;
        end
        result_o.key_out = latched_d;
      end
      MODE_READ_KEY: begin
        if (!is_fn_key(cfg_i, latched_q)) latched_d = cfg_i.no_key_code;
      end
      MODE_READ_FN: begin
        if (is_fn_key(cfg_i, latched_q)) latched_d = cfg_i.no_key_code;
      end
      default: begin
        latched_d = latched_q; // undefined mode reads without consuming
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      hold_q    <= '0;
      idle_q    <= '0;
      latched_q <= '0;
    end else if (advance_i) begin
      prev_q    <= prev_d;
      hold_q    <= hold_d;
      idle_q    <= idle_d;
      latched_q <= latched_d;
    end
  end

endmodule

// ===== rtl/key_debounce_latch.sv =====
// Key debounce latch: debounces key-code samples, latches keys, serves reads.
// An input transaction passes through the input register and then the result register
// before its result transaction; throughput 1 item/cycle while out_o.ready stays high, set by
// the input register feeding the result register.
// rst_ni (async, active low) clears the key state, result valid and config to defaults.
// Depends on kdl_pkg, kdl_if, kdl_cfg_regs and kdl_core.
module key_debounce_latch (
  input  logic       clk_i,
  input  logic       rst_ni,
  kdl_in_if.sink     in_i,
  kdl_out_if.source  out_o,
  kdl_cfg_if.sink    cfg_i
);
  import kdl_pkg::*;

  cfg_t    cfg;
  result_t result;

  // Input register stage.
  logic  in_valid_q;
  item_t in_item_q;

  // Result register stage.
  logic    out_valid_q;
  result_t out_q;

  logic out_free;
  logic advance;

  // The result register frees when empty or when its transaction completes;
  // the input stage advances into it whenever it holds an item and it is free.
  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || advance;

  assign out_o.valid   = out_valid_q;
  assign out_o.key_out = out_q.key_out;
  assign out_o.beep    = out_q.beep;

  kdl_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Key state updates in the same edge the item moves to the result register,
  // so the next item in the input register always sees up-to-date state.
  kdl_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (in_item_q),
    .advance_i (advance),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers: capture on transaction, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q.mode        <= in_i.mode;
      in_item_q.key_sample  <= in_i.key_sample;
      in_item_q.powered_off <= in_i.powered_off;
    end
    if (advance) begin
      out_q <= result;
    end
  end

endmodule
